// File: hdl/qte_pkg.sv
// Shared constants, widths and the CORDIC arctangent table for the
// quaternion to Euler angle core. No dependencies.
package qte_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int QW      = 18;   // quaternion component width
    localparam int ROLL_W  = 19;
    localparam int PITCH_W = 18;
    localparam int YAW_W   = 19;
    localparam int PROD_W  = 36;   // 18 x 18 signed product

    localparam int ZW       = 34;  // Q30 angle accumulator
    localparam int SQ_W     = 62;  // square root radicand
    localparam int SQ_STEPS = 31;  // root digits for a radicand below 2^62
    localparam int MAX_STEPS = 30;

    localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic [31:0]          Q30_ONE     = 32'h4000_0000;

    // Width of a CORDIC operand: covers 2^(2F) plus growth and pre-rotation.
    function automatic int arg_width(input int fb);
        return ((2 * fb > 37) ? 2 * fb : 37) + 4;
    endfunction

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sh3243F6A8;
            1:  v = 34'sh1DAC6705;
            2:  v = 34'sh0FADBAFC;
            3:  v = 34'sh07F56EA6;
            4:  v = 34'sh03FEAB76;
            5:  v = 34'sh01FFD55B;
            6:  v = 34'sh00FFFAAA;
            7:  v = 34'sh007FFF55;
            8:  v = 34'sh003FFFEA;
            9:  v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            24: v = 34'sh0000003F;
            25: v = 34'sh0000001F;
            26: v = 34'sh0000000F;
            27: v = 34'sh00000007;
            28: v = 34'sh00000003;
            29: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/qte_if.sv
// Valid/ready channel interfaces for quaternion beats in and Euler beats out.
// Depends on qte_pkg.
interface qte_in_if;
    import qte_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    import qte_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [YAW_W-1:0]   yaw_angle;
    logic                      pitch_clamped;
    modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
    modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 output ready);
endinterface

// File: hdl/qte_sqrt_cell.sv
// One digit of the restoring integer square root, registered.
// Carries a side payload along with the partial root. Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [qte_pkg::SQ_W-1:0] i_rad,
    input  logic [qte_pkg::SQ_W-1:0] i_root,
    input  logic [PW-1:0]            i_side,
    output logic [qte_pkg::SQ_W-1:0] o_rad,
    output logic [qte_pkg::SQ_W-1:0] o_root,
    output logic [PW-1:0]            o_side
);
    import qte_pkg::*;

    logic [SQ_W-1:0] bitv, trial, n_rad, n_root;
    logic [SQ_W-1:0] r_rad, r_root;
    logic [PW-1:0]   r_side;
    logic            ge;

    always_comb begin
        bitv  = SQ_W'(1) << (2 * K);
        trial = i_root + bitv;
        ge    = (i_rad >= trial);
        n_rad  = ge ? (i_rad - trial) : i_rad;
        n_root = ge ? ((i_root >> 1) + bitv) : (i_root >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rad  = r_rad;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

// File: hdl/qte_cordic_cell.sv
// One vectoring CORDIC iteration, registered, with a side payload.
// Depends on qte_pkg for the arctangent table.
module qte_cordic_cell #(
    parameter int STEP = 0,
    parameter int AW   = 41,
    parameter int PW   = 1
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [AW-1:0]          i_x,
    input  logic signed [AW-1:0]          i_y,
    input  logic signed [qte_pkg::ZW-1:0] i_z,
    input  logic [PW-1:0]                 i_side,
    output logic signed [AW-1:0]          o_x,
    output logic signed [AW-1:0]          o_y,
    output logic signed [qte_pkg::ZW-1:0] o_z,
    output logic [PW-1:0]                 o_side
);
    import qte_pkg::*;

    logic signed [AW-1:0] xs, ys, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z;
    logic [PW-1:0]        r_side;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (!i_y[AW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + atan_q30(STEP);
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - atan_q30(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;
endmodule

// File: hdl/quaternion_to_euler_angles_core.sv
// Quaternion to ZYX Euler angles. Pipeline: 4 front stages, 31 square root
// digit cells, a pre-rotation stage, one cell per CORDIC iteration and an
// output stage. Throughput one beat per cycle; the whole pipeline holds
// while the output beat waits.
// Synchronous active-low reset clears the valid pipeline only.
// Depends on qte_pkg, qte_if, qte_sqrt_cell and qte_cordic_cell.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STEPS  = qte_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = qte_pkg::FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qte_in_if.sink       i_quat,
    qte_out_if.source    o_euler
);
    import qte_pkg::*;

    localparam int NS    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int AW    = arg_width(FRACTION_BITS);
    localparam int LAT   = 4 + SQ_STEPS + 1 + NS + 1;
    localparam int SH    = 30 - FRACTION_BITS;
    localparam int RS    = (SH > 0) ? SH - 1 : 0;
    localparam int PSH_R = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
    localparam int PSH_L = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;
    localparam int SPW   = 4 * AW + 32 + 2;
    localparam logic signed [AW-1:0] ONE_A = AW'(1) <<< (2 * FRACTION_BITS);
    localparam logic signed [ZW-1:0] RND   = (SH > 0) ? (ZW'(1) <<< RS) : ZW'(0);

    logic           adv;
    logic [LAT-1:0] r_vld;

    assign adv          = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = adv;
    assign o_euler.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    // stage 0: products
    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wx <= PROD_W'(i_quat.quat_w) * PROD_W'(i_quat.quat_x);
            r_yz <= PROD_W'(i_quat.quat_y) * PROD_W'(i_quat.quat_z);
            r_xx <= PROD_W'(i_quat.quat_x) * PROD_W'(i_quat.quat_x);
            r_yy <= PROD_W'(i_quat.quat_y) * PROD_W'(i_quat.quat_y);
            r_wz <= PROD_W'(i_quat.quat_w) * PROD_W'(i_quat.quat_z);
            r_xy <= PROD_W'(i_quat.quat_x) * PROD_W'(i_quat.quat_y);
            r_zz <= PROD_W'(i_quat.quat_z) * PROD_W'(i_quat.quat_z);
            r_wy <= PROD_W'(i_quat.quat_w) * PROD_W'(i_quat.quat_y);
            r_zx <= PROD_W'(i_quat.quat_z) * PROD_W'(i_quat.quat_x);
        end
    end

    // stage 1: atan2 arguments and pitch sine
    logic signed [AW-1:0] r1_rx, r1_ry, r1_yx, r1_yy, r1_sp;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ry <= (AW'(r_wx) + AW'(r_yz)) <<< 1;
            r1_rx <= ONE_A - ((AW'(r_xx) + AW'(r_yy)) <<< 1);
            r1_yy <= (AW'(r_wz) + AW'(r_xy)) <<< 1;
            r1_yx <= ONE_A - ((AW'(r_yy) + AW'(r_zz)) <<< 1);
            r1_sp <= (AW'(r_wy) - AW'(r_zx)) <<< 1;
        end
    end

    // stage 2: clamp test, sine in Q30, factors of 1 - s^2
    logic signed [AW-1:0] s30_w;
    logic signed [31:0]   n_s30;
    logic signed [AW-1:0] r2_rx, r2_ry, r2_yx, r2_yy;
    logic signed [31:0]   r2_s30;
    logic [31:0]          r2_a, r2_b;
    logic                 r2_clamp, r2_pos;

    always_comb begin
        s30_w = (r1_sp >>> PSH_R) <<< PSH_L;
        n_s30 = s30_w[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_rx    <= r1_rx;
            r2_ry    <= r1_ry;
            r2_yx    <= r1_yx;
            r2_yy    <= r1_yy;
            r2_s30   <= n_s30;
            r2_a     <= Q30_ONE - n_s30;
            r2_b     <= Q30_ONE + n_s30;
            r2_clamp <= (r1_sp >= ONE_A) || (r1_sp <= -ONE_A);
            r2_pos   <= (r1_sp > 0);
        end
    end

    // stage 3: radicand
    logic [63:0]      prod;
    logic [SQ_W-1:0]  r3_rad;
    logic [SPW-1:0]   r3_side;
    assign prod = 64'(r2_a) * 64'(r2_b);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_rad  <= prod[SQ_W-1:0];
            r3_side <= {r2_rx, r2_ry, r2_yx, r2_yy, r2_s30, r2_clamp, r2_pos};
        end
    end

    // square root chain, one root digit per cell
    logic [SQ_W-1:0] sq_rad  [SQ_STEPS+1];
    logic [SQ_W-1:0] sq_root [SQ_STEPS+1];
    logic [SPW-1:0]  sq_side [SQ_STEPS+1];

    assign sq_rad[0]  = r3_rad;
    assign sq_root[0] = '0;
    assign sq_side[0] = r3_side;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        qte_sqrt_cell #(
            .K  (SQ_STEPS - 1 - j),
            .PW (SPW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_rad  (sq_rad[j]),
            .i_root (sq_root[j]),
            .i_side (sq_side[j]),
            .o_rad  (sq_rad[j+1]),
            .o_root (sq_root[j+1]),
            .o_side (sq_side[j+1])
        );
    end

    // unpack; lanes: 0 roll, 1 pitch, 2 yaw
    logic signed [AW-1:0] ax [3];
    logic signed [AW-1:0] ay [3];
    logic signed [31:0]   q_s30;
    logic                 q_clamp, q_pos;
    logic [SQ_W-1:0]      q_root;

    always_comb begin
        {ax[0], ay[0], ax[2], ay[2], q_s30, q_clamp, q_pos} = sq_side[SQ_STEPS];
        q_root = sq_root[SQ_STEPS];
        ay[1]  = AW'(q_s30);
        ax[1]  = AW'($signed({1'b0, q_root[30:0]}));
    end

    // per lane: pre-rotation into the right half plane, CORDIC cells, output rounding
    logic signed [AW-1:0] cx [3][NS+1];
    logic signed [AW-1:0] cy [3][NS+1];
    logic signed [ZW-1:0] cz [3][NS+1];
    logic [2:0]           cs [3][NS+1];
    logic signed [ZW-1:0] zq [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [AW-1:0] n_px, n_py;
        logic signed [ZW-1:0] n_pz, zc, zsel;
        logic                 n_zero;

        always_comb begin
            n_zero = (ax[l] == '0) && (ay[l] == '0);
            n_px   = ax[l];
            n_py   = ay[l];
            n_pz   = '0;
            if (ax[l][AW-1]) begin
                if (!ay[l][AW-1]) begin
                    n_px = ay[l];
                    n_py = -ax[l];
                    n_pz = Q30_HALF_PI;
                end else begin
                    n_px = -ay[l];
                    n_py = ax[l];
                    n_pz = -Q30_HALF_PI;
                end
            end
        end

        logic signed [AW-1:0] r_px, r_py;
        logic signed [ZW-1:0] r_pz;
        logic [2:0]           r_ps;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_px <= n_px;
                r_py <= n_py;
                r_pz <= n_pz;
                r_ps <= {n_zero, q_clamp, q_pos};
            end
        end

        assign cx[l][0] = r_px;
        assign cy[l][0] = r_py;
        assign cz[l][0] = r_pz;
        assign cs[l][0] = r_ps;

        for (genvar i = 0; i < NS; i++) begin : g_step
            qte_cordic_cell #(
                .STEP (i),
                .AW   (AW),
                .PW   (3)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_x    (cx[l][i]),
                .i_y    (cy[l][i]),
                .i_z    (cz[l][i]),
                .i_side (cs[l][i]),
                .o_x    (cx[l][i+1]),
                .o_y    (cy[l][i+1]),
                .o_z    (cz[l][i+1]),
                .o_side (cs[l][i+1])
            );
        end

        always_comb begin
            zc = cz[l][NS];
            if (zc > Q30_PI) begin
                zc = Q30_PI;
            end
            if (zc < -Q30_PI) begin
                zc = -Q30_PI;
            end
            if (cs[l][NS][2]) begin
                zc = '0;
            end
            zsel = zc;
            // pitch lane: saturate to a quarter turn when the sine hit one
            if ((l == 1) && cs[l][NS][1]) begin
                zsel = cs[l][NS][0] ? Q30_HALF_PI : -Q30_HALF_PI;
            end
            zq[l] = (zsel + RND) >>> SH;
        end
    end

    // output register
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [YAW_W-1:0]   r_yaw;
    logic                      r_flag;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll  <= zq[0][ROLL_W-1:0];
            r_pitch <= zq[1][PITCH_W-1:0];
            r_yaw   <= zq[2][YAW_W-1:0];
            r_flag  <= cs[1][NS][1];
        end
    end

    assign o_euler.roll_angle    = r_roll;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.yaw_angle     = r_yaw;
    assign o_euler.pitch_clamped = r_flag;
endmodule
